// File: hdl/rtt_pkg.sv
// Shared types, widths and codes of the region translation table.
`timescale 1ns / 1ps
package rtt_pkg;

	// Number of cells in the chain, one table entry per cell.
	localparam int TABLE_ENTRIES = 16;

	localparam int CNT_W    = $clog2(TABLE_ENTRIES + 1);
	localparam int REQ_W    = 2;
	localparam int PID_W    = 22;
	localparam int ADDR_W   = 48;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 4;
	localparam int HELD_W   = 5;

	typedef logic [CNT_W-1:0] rtt_pos_t;

	typedef enum logic [REQ_W-1:0] {
		REQ_FIND   = 2'd0,
		REQ_LOOKUP = 2'd1,
		REQ_REMOVE = 2'd2
	} rtt_req_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_HIT       = 3'd0,
		STAT_INSERTED  = 3'd1,
		STAT_REMOVED   = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_FULL      = 3'd4
	} rtt_status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_LAUNCH,
		FSM_SCAN,
		FSM_RESP
	} rtt_state_t;

	// Request held for the length of one operation and broadcast to every cell.
	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [PID_W-1:0]  pid;
		logic [ADDR_W-1:0] caddr;
		logic [ADDR_W-1:0] saddr;
		logic [ADDR_W-1:0] len;
		logic [ADDR_W-1:0] offs;
	} rtt_query_t;

	// Contents of one table entry.
	typedef struct packed {
		logic [PID_W-1:0]  pid;
		logic [ADDR_W-1:0] caddr;
		logic [ADDR_W-1:0] saddr;
		logic [ADDR_W-1:0] len;
		logic [ADDR_W-1:0] offs;
	} rtt_entry_t;

	// Search token handed from cell to cell, one cell per cycle.
	typedef struct packed {
		logic              vld;
		logic              found;
		rtt_pos_t          slot;
		logic [ADDR_W-1:0] caddr;
		logic [ADDR_W-1:0] saddr;
		logic [ADDR_W-1:0] len;
		logic [ADDR_W-1:0] offs;
	} rtt_token_t;

	// Update command broadcast to the cells when a search completes.
	typedef struct packed {
		logic     ins;
		logic     rem;
		rtt_pos_t pos;
	} rtt_cmd_t;

endpackage

// File: hdl/rtt_ifs.sv
// Request and response channel interfaces of the region translation table.
`timescale 1ns / 1ps
interface rtt_req_if;
	logic                        valid;
	logic                        ready;
	logic [rtt_pkg::REQ_W-1:0]   req_type;
	logic [rtt_pkg::PID_W-1:0]   process_id;
	logic [rtt_pkg::ADDR_W-1:0]  client_address;
	logic [rtt_pkg::ADDR_W-1:0]  server_address;
	logic [rtt_pkg::ADDR_W-1:0]  region_length;
	logic [rtt_pkg::ADDR_W-1:0]  region_offset;

	modport source (
		output valid, req_type, process_id, client_address, server_address,
			region_length, region_offset,
		input  ready
	);
	modport sink (
		input  valid, req_type, process_id, client_address, server_address,
			region_length, region_offset,
		output ready
	);
endinterface

interface rtt_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [rtt_pkg::STATUS_W-1:0]  status;
	logic [rtt_pkg::SLOT_W-1:0]    slot;
	logic [rtt_pkg::ADDR_W-1:0]    found_server_address;
	logic [rtt_pkg::ADDR_W-1:0]    found_client_address;
	logic [rtt_pkg::ADDR_W-1:0]    found_length;
	logic [rtt_pkg::ADDR_W-1:0]    found_offset;
	logic [rtt_pkg::HELD_W-1:0]    entries_held;

	modport source (
		output valid, status, slot, found_server_address, found_client_address,
			found_length, found_offset, entries_held,
		input  ready
	);
	modport sink (
		input  valid, status, slot, found_server_address, found_client_address,
			found_length, found_offset, entries_held,
		output ready
	);
endinterface

// File: hdl/region_translation_table_top.sv
// Top level of the region translation table: sequencer and the chain of entry cells.
`timescale 1ns / 1ps
// The table keeps up to TABLE_ENTRIES mapped regions in insertion order, one per
// cell of a chain. A request is accepted only while the block is idle; the cycle
// after acceptance a search token enters the first cell and moves one cell per
// cycle down the chain, recording the first entry that matches the request. When
// the token leaves the last cell the sequencer commits the outcome: an insert
// writes the cell just past the last valid entry, a removal makes the matching
// cell and every later cell take its neighbour's entry together. The response is
// registered, and a new request can be taken in the cycle after the response is
// taken; the length of the cell chain sets how long each search takes. The table
// is empty straight after reset; no clearing pass is needed, since every cell
// carries its own valid bit cleared by reset.
module region_translation_table_top (
	input  logic    clk,
	input  logic    arst_n,
	rtt_req_if.sink   req,
	rtt_rsp_if.source rsp
);

	rtt_pkg::rtt_query_t query;
	rtt_pkg::rtt_cmd_t   cmd;

	// Token path: tok[k] enters cell k, tok[TABLE_ENTRIES] is the tail.
	rtt_pkg::rtt_token_t tok [rtt_pkg::TABLE_ENTRIES+1];

	// Entry path for removal: cell k reads ent[k+1]; past the end sits an empty entry.
	rtt_pkg::rtt_entry_t ent [rtt_pkg::TABLE_ENTRIES+1];
	logic                vld [rtt_pkg::TABLE_ENTRIES+1];

	assign ent[rtt_pkg::TABLE_ENTRIES] = '0;
	assign vld[rtt_pkg::TABLE_ENTRIES] = 1'b0;

	rtt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.query    (query),
		.tok_head (tok[0]),
		.tok_tail (tok[rtt_pkg::TABLE_ENTRIES]),
		.cmd      (cmd)
	);

	for (genvar k = 0; k < rtt_pkg::TABLE_ENTRIES; k++) begin : g_cell
		rtt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_pos  (rtt_pkg::rtt_pos_t'(k)),
			.query     (query),
			.cmd       (cmd),
			.tok_in    (tok[k]),
			.tok_out   (tok[k+1]),
			.nxt_entry (ent[k+1]),
			.nxt_valid (vld[k+1]),
			.entry     (ent[k]),
			.valid     (vld[k])
		);
	end

endmodule

// File: hdl/rtt_cell.sv
// One table cell: holds one entry, matches the passing search token and shifts on removal.
`timescale 1ns / 1ps
module rtt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  rtt_pkg::rtt_pos_t   cell_pos,
	input  rtt_pkg::rtt_query_t query,
	input  rtt_pkg::rtt_cmd_t   cmd,
	input  rtt_pkg::rtt_token_t tok_in,
	output rtt_pkg::rtt_token_t tok_out,
	input  rtt_pkg::rtt_entry_t nxt_entry,
	input  logic                nxt_valid,
	output rtt_pkg::rtt_entry_t entry,
	output logic                valid
);

	rtt_pkg::rtt_entry_t        entry_q;
	logic                       valid_q;
	rtt_pkg::rtt_token_t        tok_q;
	logic                       hit;
	logic                       key_match;
	logic [rtt_pkg::ADDR_W:0]   end_sum;
	logic                       take_ins;
	logic                       take_shift;

	assign end_sum = {1'b0, entry_q.offs} + {1'b0, entry_q.len};

	always_comb begin
		unique case (query.req_type)
			rtt_pkg::REQ_FIND:   key_match = (entry_q.caddr == query.caddr);
			rtt_pkg::REQ_LOOKUP: key_match = (query.offs >= entry_q.offs)
				&& ({1'b0, query.offs} < end_sum);
			rtt_pkg::REQ_REMOVE: key_match = (entry_q.offs == query.offs);
			default:             key_match = 1'b0;
		endcase
	end

	assign hit = valid_q && (entry_q.pid == query.pid) && key_match;

	// The token records the first matching cell; later cells only pass it on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.vld   <= tok_in.vld;
			tok_q.found <= tok_in.found || (tok_in.vld && hit);
			if (tok_in.vld && !tok_in.found && hit) begin
				tok_q.slot  <= cell_pos;
				tok_q.caddr <= entry_q.caddr;
				tok_q.saddr <= entry_q.saddr;
				tok_q.len   <= entry_q.len;
				tok_q.offs  <= entry_q.offs;
			end else begin
				tok_q.slot  <= tok_in.slot;
				tok_q.caddr <= tok_in.caddr;
				tok_q.saddr <= tok_in.saddr;
				tok_q.len   <= tok_in.len;
				tok_q.offs  <= tok_in.offs;
			end
		end
	end

	assign take_ins   = cmd.ins && (cmd.pos == cell_pos);
	assign take_shift = cmd.rem && (cell_pos >= cmd.pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_ins) begin
			valid_q <= 1'b1;
		end else if (take_shift) begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_ins) begin
			entry_q.pid   <= query.pid;
			entry_q.caddr <= query.caddr;
			entry_q.saddr <= query.saddr;
			entry_q.len   <= query.len;
			entry_q.offs  <= query.offs;
		end else if (take_shift) begin
			entry_q <= nxt_entry;
		end
	end

	assign tok_out = tok_q;
	assign entry   = entry_q;
	assign valid   = valid_q;

endmodule

// File: hdl/rtt_ctrl.sv
// Sequencer: takes a request, launches the search token and commits the outcome.
`timescale 1ns / 1ps
module rtt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	rtt_req_if.sink              req,
	rtt_rsp_if.source            rsp,
	output rtt_pkg::rtt_query_t  query,
	output rtt_pkg::rtt_token_t  tok_head,
	input  rtt_pkg::rtt_token_t  tok_tail,
	output rtt_pkg::rtt_cmd_t    cmd
);

	rtt_pkg::rtt_state_t         state_q;
	rtt_pkg::rtt_state_t         state_nxt;
	rtt_pkg::rtt_query_t         query_q;
	rtt_pkg::rtt_pos_t           cnt_q;
	rtt_pkg::rtt_pos_t           cnt_nxt;
	logic                        commit;
	rtt_pkg::rtt_cmd_t           dec_cmd;
	logic [rtt_pkg::STATUS_W-1:0] dec_status;
	rtt_pkg::rtt_pos_t           dec_slot;
	rtt_pkg::rtt_entry_t         dec_entry;

	logic [rtt_pkg::STATUS_W-1:0] status_q;
	rtt_pkg::rtt_pos_t           slot_q;
	rtt_pkg::rtt_entry_t         found_q;
	rtt_pkg::rtt_pos_t           held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtt_pkg::FSM_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rtt_pkg::FSM_IDLE:   if (req.valid) state_nxt = rtt_pkg::FSM_LAUNCH;
			rtt_pkg::FSM_LAUNCH: state_nxt = rtt_pkg::FSM_SCAN;
			rtt_pkg::FSM_SCAN:   if (tok_tail.vld) state_nxt = rtt_pkg::FSM_RESP;
			rtt_pkg::FSM_RESP:   if (rsp.ready) state_nxt = rtt_pkg::FSM_IDLE;
			default:             state_nxt = rtt_pkg::FSM_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == rtt_pkg::FSM_IDLE);
		rsp.valid = (state_q == rtt_pkg::FSM_RESP);
		commit    = (state_q == rtt_pkg::FSM_SCAN) && tok_tail.vld;
		tok_head  = '0;
		tok_head.vld = (state_q == rtt_pkg::FSM_LAUNCH);
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			query_q.req_type <= req.req_type;
			query_q.pid      <= req.process_id;
			query_q.caddr    <= req.client_address;
			query_q.saddr    <= req.server_address;
			query_q.len      <= req.region_length;
			query_q.offs     <= req.region_offset;
		end
	end

	assign query = query_q;

	// Outcome of the finished search.
	always_comb begin
		dec_cmd          = '0;
		dec_status       = rtt_pkg::STAT_NOT_FOUND;
		dec_slot         = '0;
		dec_entry        = '0;
		cnt_nxt          = cnt_q;
		dec_entry.caddr  = tok_tail.caddr;
		if (tok_tail.found) begin
			dec_slot        = tok_tail.slot;
			dec_entry.caddr = tok_tail.caddr;
			dec_entry.saddr = tok_tail.saddr;
			dec_entry.len   = tok_tail.len;
			dec_entry.offs  = tok_tail.offs;
		end else begin
			dec_entry = '0;
		end
		unique case (query_q.req_type)
			rtt_pkg::REQ_FIND: begin
				if (tok_tail.found) begin
					dec_status = rtt_pkg::STAT_HIT;
				end else if (cnt_q < rtt_pkg::rtt_pos_t'(rtt_pkg::TABLE_ENTRIES)) begin
					dec_status      = rtt_pkg::STAT_INSERTED;
					dec_slot        = cnt_q;
					dec_entry.pid   = query_q.pid;
					dec_entry.caddr = query_q.caddr;
					dec_entry.saddr = query_q.saddr;
					dec_entry.len   = query_q.len;
					dec_entry.offs  = query_q.offs;
					dec_cmd.ins     = 1'b1;
					dec_cmd.pos     = cnt_q;
					cnt_nxt         = rtt_pkg::rtt_pos_t'(cnt_q + 1'b1);
				end else begin
					dec_status = rtt_pkg::STAT_FULL;
				end
			end
			rtt_pkg::REQ_LOOKUP: begin
				dec_status = tok_tail.found ? rtt_pkg::STAT_HIT : rtt_pkg::STAT_NOT_FOUND;
			end
			rtt_pkg::REQ_REMOVE: begin
				if (tok_tail.found) begin
					dec_status  = rtt_pkg::STAT_REMOVED;
					dec_cmd.rem = 1'b1;
					dec_cmd.pos = tok_tail.slot;
					cnt_nxt     = rtt_pkg::rtt_pos_t'(cnt_q - 1'b1);
				end
			end
			default: begin
				dec_status = rtt_pkg::STAT_NOT_FOUND;
			end
		endcase
	end

	assign cmd = commit ? dec_cmd : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (commit) begin
			cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= dec_status;
			slot_q   <= dec_slot;
			found_q  <= dec_entry;
			held_q   <= cnt_nxt;
		end
	end

	assign rsp.status               = status_q;
	assign rsp.slot                 = rtt_pkg::SLOT_W'(slot_q);
	assign rsp.found_server_address = found_q.saddr;
	assign rsp.found_client_address = found_q.caddr;
	assign rsp.found_length         = found_q.len;
	assign rsp.found_offset         = found_q.offs;
	assign rsp.entries_held         = rtt_pkg::HELD_W'(held_q);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= rtt_pkg::rtt_pos_t'(rtt_pkg::TABLE_ENTRIES))
		else $error("entry count beyond table size");

	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok_tail.vld |-> state_q == rtt_pkg::FSM_SCAN)
		else $error("search token left the chain outside a scan");

	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |-> (cnt_q < rtt_pkg::rtt_pos_t'(rtt_pkg::TABLE_ENTRIES)) && !cmd.rem)
		else $error("insert into a full table or together with a removal");

	a_rem_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rem |=> cnt_q == rtt_pkg::rtt_pos_t'($past(cnt_q) - 1'b1))
		else $error("removal did not lower the entry count");

endmodule
